@@ sv/assert_macros.svh @@
// Assertion macros shared by the deque checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define DQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge while reset is held.
`define DQ_ASSERT_IN_RESET(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`endif

@@ sv/dq_pkg.sv @@
// Shared types and constants of the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int unsigned DEF_CAPACITY = 1024;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned IDX_W        = 11;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned REQ_W        = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ       = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_WRITE = 2'd1,
    MEM_READ  = 2'd2
  } mem_op_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    mem_op_e op;
    count_t  count;
    status_e status;
  } ctl_t;

endpackage

`default_nettype wire

@@ sv/dq_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module dq_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 2,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/dq_front.sv @@
// Front end: accepts requests, keeps front pointer and count, classifies.
`default_nettype none

module dq_front #(
  parameter  int unsigned CAPACITY = dq_pkg::DEF_CAPACITY,
  localparam int unsigned PTR_W    = $clog2(CAPACITY),
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1),
  localparam int unsigned CMP_W    = (CNT_W > 12) ? CNT_W : 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 q_full_i,
  input  logic        [dq_pkg::REQ_W-1:0]      req_type_i,
  input  logic signed [dq_pkg::DATA_W-1:0]     value_i,
  input  logic signed [dq_pkg::IDX_W-1:0]      index_i,
  output logic                                 push_o,
  output dq_pkg::ctl_t                         ctl_o,
  output logic        [PTR_W-1:0]              addr_o,
  output logic        [dq_pkg::DATA_W-1:0]     data_o
);

  localparam logic [PTR_W:0]   CapExt  = (PTR_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CapCnt  = CNT_W'(CAPACITY);
  localparam logic [PTR_W-1:0] LastPos = PTR_W'(CAPACITY - 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] front_q, front_d;

  logic                    accept;
  logic                    full, empty;
  logic                    idx_neg, rd_ok;
  logic signed [CMP_W-1:0] idx_s;
  logic        [CMP_W-1:0] idx_u, mag_u, cnt_ext, off_ext;
  logic        [PTR_W-1:0] front_inc, front_dec;

  // Wrap base + off into the ring; both are below CAPACITY.
  function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CapExt) begin
      sum = sum - CapExt;
    end
    return sum[PTR_W-1:0];
  endfunction

  assign accept    = start_i & ~q_full_i;
  assign full      = (cnt_q == CapCnt);
  assign empty     = (cnt_q == '0);
  assign front_inc = (front_q == LastPos) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LastPos : front_q - 1'b1;

  assign idx_s   = CMP_W'(index_i);
  assign idx_u   = idx_s;
  assign idx_neg = idx_s[CMP_W-1];
  assign mag_u   = '0 - idx_u;
  assign cnt_ext = CMP_W'(cnt_q);
  assign rd_ok   = idx_neg ? (mag_u <= cnt_ext) : (idx_u < cnt_ext);
  assign off_ext = idx_neg ? (cnt_ext - mag_u) : idx_u;

  always_comb begin
    cnt_d        = cnt_q;
    front_d      = front_q;
    ctl_o.op     = dq_pkg::MEM_NONE;
    ctl_o.status = dq_pkg::ST_OK;
    addr_o       = '0;
    if (accept) begin
      unique case (dq_pkg::req_e'(req_type_i))
        dq_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            ctl_o.status = dq_pkg::ST_FULL;
          end else begin
            ctl_o.op = dq_pkg::MEM_WRITE;
            addr_o   = ring_pos(front_q, cnt_q[PTR_W-1:0]);
            cnt_d    = cnt_q + 1'b1;
          end
        end
        dq_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            ctl_o.status = dq_pkg::ST_FULL;
          end else begin
            ctl_o.op = dq_pkg::MEM_WRITE;
            addr_o   = front_dec;
            front_d  = front_dec;
            cnt_d    = cnt_q + 1'b1;
          end
        end
        dq_pkg::REQ_POP_BACK: begin
          if (empty) begin
            ctl_o.status = dq_pkg::ST_EMPTY;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        dq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            ctl_o.status = dq_pkg::ST_EMPTY;
          end else begin
            front_d = front_inc;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        dq_pkg::REQ_READ: begin
          if (rd_ok) begin
            ctl_o.op = dq_pkg::MEM_READ;
            addr_o   = ring_pos(front_q, off_ext[PTR_W-1:0]);
          end else begin
            ctl_o.status = dq_pkg::ST_RANGE;
          end
        end
        dq_pkg::REQ_CLEAR: begin
          cnt_d   = '0;
          front_d = '0;
        end
        default: begin
        end
      endcase
    end
    ctl_o.count = dq_pkg::count_t'(cnt_d);
  end

  assign push_o = accept;
  assign data_o = value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      front_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      front_q <= front_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/dq_queue.sv @@
// Short FIFO of classified requests between front and back.
`default_nettype none

module dq_queue #(
  parameter  int unsigned ADDR_W = 10,
  localparam int unsigned DEPTH  = dq_pkg::QUEUE_DEPTH,
  localparam int unsigned PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned FW     = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  dq_pkg::ctl_t                  ctl_i,
  input  logic [ADDR_W-1:0]             addr_i,
  input  logic [dq_pkg::DATA_W-1:0]     data_i,
  input  logic                          pop_i,
  output logic                          full_o,
  output logic                          valid_o,
  output dq_pkg::ctl_t                  ctl_o,
  output logic [ADDR_W-1:0]             addr_o,
  output logic [dq_pkg::DATA_W-1:0]     data_o
);

  localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);
  localparam logic [FW-1:0] FullCnt  = FW'(DEPTH);

  dq_pkg::ctl_t              ctl_mem_q  [DEPTH];
  logic [ADDR_W-1:0]         addr_mem_q [DEPTH];
  logic [dq_pkg::DATA_W-1:0] data_mem_q [DEPTH];

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == FullCnt);
  assign valid_o = (fill_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  assign ctl_o  = ctl_mem_q[rd_ptr_q];
  assign addr_o = addr_mem_q[rd_ptr_q];
  assign data_o = data_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ctl_mem_q[wr_ptr_q]  <= ctl_i;
      addr_mem_q[wr_ptr_q] <= addr_i;
      data_mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/dq_back.sv @@
// Back end: carries out the ring store access and drives the result.
`default_nettype none

module dq_back #(
  parameter  int unsigned CAPACITY = dq_pkg::DEF_CAPACITY,
  localparam int unsigned PTR_W    = $clog2(CAPACITY)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  dq_pkg::ctl_t                         ctl_i,
  input  logic        [PTR_W-1:0]              addr_i,
  input  logic        [dq_pkg::DATA_W-1:0]     data_i,
  output logic                                 pop_o,
  output logic                                 done_o,
  output logic signed [dq_pkg::DATA_W-1:0]     read_value_o,
  output logic        [dq_pkg::COUNT_W-1:0]    count_o,
  output logic        [dq_pkg::STATUS_W-1:0]   status_o
);

  logic                      done_q;
  dq_pkg::ctl_t              ctl_q;
  logic                      ram_we, ram_re;
  logic [dq_pkg::DATA_W-1:0] ram_rdata;

  // Drain one request per cycle; the receiver never holds results off.
  assign pop_o  = valid_i;
  assign ram_we = valid_i && (ctl_i.op == dq_pkg::MEM_WRITE);
  assign ram_re = valid_i && (ctl_i.op == dq_pkg::MEM_READ);

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr_i),
    .wdata_i (data_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctl_q <= ctl_i;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = (done_q && (ctl_q.op == dq_pkg::MEM_READ)) ? ram_rdata : '0;
  assign count_o      = ctl_q.count;
  assign status_o     = ctl_q.status;

endmodule

`default_nettype wire

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue of signed 64-bit words.
`default_nettype none

// Double-ended queue over a fixed ring store of CAPACITY 64-bit words.
// A request is taken at a rising edge with start high and busy low; the
// front end decodes it at once against the front pointer and element count,
// updates both, and drops a classified request into a two-entry queue. The
// back end pulls one request per cycle from that queue, performs the single
// ring store write or read, and presents the result on done_o for exactly
// one cycle; a request passes first through the queue entry, then through
// the done register and the registered read port of the store. Results
// cannot be held off, so the back end never stalls and the queue never fills
// in practice: one request can be accepted every cycle.
// Every request yields one result: count_o is the element count after the
// request (low 11 bits), status_o flags a push on a full queue, a pop on an
// empty one, or a read index out of range; read_value_o carries the element
// for a successful read and zero otherwise. A non-negative index counts from
// the front, a negative one from the back (-1 is the last element). Clear
// resets pointer and count; the store is not cleared, since only entries
// inside the live window are ever read, so no clearing pass follows reset.
// Request codes 6 and 7 change nothing and answer ok.
module double_ended_queue #(
  parameter  int unsigned CAPACITY = dq_pkg::DEF_CAPACITY,
  localparam int unsigned PTR_W    = $clog2(CAPACITY)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [dq_pkg::REQ_W-1:0]      req_type_i,
  input  logic signed [dq_pkg::DATA_W-1:0]     value_i,
  input  logic signed [dq_pkg::IDX_W-1:0]      index_i,
  output logic                                 done_o,
  output logic signed [dq_pkg::DATA_W-1:0]     read_value_o,
  output logic        [dq_pkg::COUNT_W-1:0]    count_o,
  output logic        [dq_pkg::STATUS_W-1:0]   status_o
);

  // Front to queue.
  logic                      fe_push;
  dq_pkg::ctl_t              fe_ctl;
  logic [PTR_W-1:0]          fe_addr;
  logic [dq_pkg::DATA_W-1:0] fe_data;

  // Queue to back.
  logic                      q_full, q_valid, be_pop;
  dq_pkg::ctl_t              q_ctl;
  logic [PTR_W-1:0]          q_addr;
  logic [dq_pkg::DATA_W-1:0] q_data;

  // Hold off new requests only while the handoff queue is full.
  assign busy = q_full;

  dq_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .q_full_i   (q_full),
    .req_type_i (req_type_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .push_o     (fe_push),
    .ctl_o      (fe_ctl),
    .addr_o     (fe_addr),
    .data_o     (fe_data)
  );

  dq_queue #(
    .ADDR_W (PTR_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .ctl_i   (fe_ctl),
    .addr_i  (fe_addr),
    .data_i  (fe_data),
    .pop_i   (be_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .ctl_o   (q_ctl),
    .addr_o  (q_addr),
    .data_o  (q_data)
  );

  dq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .ctl_i        (q_ctl),
    .addr_i       (q_addr),
    .data_i       (q_data),
    .pop_o        (be_pop),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

@@ sv/dq_checker.sv @@
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module dq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic        [dq_pkg::REQ_W-1:0]    req_type_i,
  input logic                               done_o,
  input logic signed [dq_pkg::DATA_W-1:0]   read_value_o,
  input logic        [dq_pkg::COUNT_W-1:0]  count_o,
  input logic        [dq_pkg::STATUS_W-1:0] status_o
);

  // Quiet while reset is held.
  `DQ_ASSERT_IN_RESET(a_reset_quiet, clk_i, rst_ni, !done_o && !busy, "result or busy in reset")

  // Every taken request is answered by a done_o strobe.
  `DQ_ASSERT(a_latency, clk_i, rst_ni, start && !busy |-> ##2 done_o, "result missing")

  // Data appears only for a read request.
  `DQ_ASSERT(a_data_only_read, clk_i, rst_ni, done_o && ($past(req_type_i, 2) != dq_pkg::REQ_READ) |-> read_value_o == '0, "data on non-read")

  // A refused request never returns data.
  `DQ_ASSERT(a_refused_zero, clk_i, rst_ni, done_o && (status_o != dq_pkg::ST_OK) |-> read_value_o == '0, "data on refused request")

  // An empty pop leaves nothing behind.
  `DQ_ASSERT(a_empty_count, clk_i, rst_ni, done_o && (status_o == dq_pkg::ST_EMPTY) |-> count_o == '0, "count on empty pop")

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_type_i   (req_type_i),
  .done_o       (done_o),
  .read_value_o (read_value_o),
  .count_o      (count_o),
  .status_o     (status_o)
);

`default_nettype wire

@@ tb/double_ended_queue_tb.sv @@
// Self-checking testbench for the double-ended queue against a deque predictor.
`timescale 1ns / 100ps

module double_ended_queue_tb;

  localparam int unsigned CAPACITY     = dq_pkg::DEF_CAPACITY;
  localparam int unsigned REQ_W        = dq_pkg::REQ_W;
  localparam int unsigned DATA_W       = dq_pkg::DATA_W;
  localparam int unsigned IDX_W        = dq_pkg::IDX_W;
  localparam int unsigned COUNT_W      = dq_pkg::COUNT_W;
  localparam int unsigned STATUS_W     = dq_pkg::STATUS_W;
  localparam int unsigned RST_CYCLES   = 12;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Stop idling once this few requests remain, so the tail runs back to back.
  localparam int unsigned NO_IDLE_TAIL = 100;

  // Request codes that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] VAL_ONES = -64'sd1;

  typedef struct {
    logic [REQ_W-1:0]         kind;
    logic signed [DATA_W-1:0] value;
    logic signed [IDX_W-1:0]  index;
  } deq_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] rd;
    dq_pkg::count_t           count;
    dq_pkg::status_e          status;
  } deq_reply_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [REQ_W-1:0]           req_type_i;
  logic signed [DATA_W-1:0]   value_i;
  logic signed [IDX_W-1:0]    index_i;
  logic                       done_o;
  logic signed [DATA_W-1:0]   read_value_o;
  logic [COUNT_W-1:0]         count_o;
  logic [STATUS_W-1:0]        status_o;

  deq_req_t   pending_reqs[$];
  deq_reply_t expected_replies[$];

  // Predictor state: ring contents, head position and element count.
  logic signed [DATA_W-1:0] ring_words [CAPACITY];
  int unsigned              ring_head = 0;
  int unsigned              ring_fill = 0;

  // Element count as seen by the stimulus generator, used to aim reads and runs.
  int unsigned gen_fill;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  bit          req_taken = 1'b0;

  double_ended_queue i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the predictor and return the reply it must produce.
  function automatic deq_reply_t deque_apply(deq_req_t r);
    deq_reply_t  rep;
    int          idx;
    int unsigned back;
    rep.rd     = '0;
    rep.status = dq_pkg::ST_OK;
    idx        = r.index;
    case (r.kind)
      dq_pkg::REQ_PUSH_BACK: begin
        if (ring_fill >= CAPACITY) begin
          rep.status = dq_pkg::ST_FULL;
        end else begin
          ring_words[(ring_head + ring_fill) % CAPACITY] = r.value;
          ring_fill++;
        end
      end
      dq_pkg::REQ_PUSH_FRONT: begin
        if (ring_fill >= CAPACITY) begin
          rep.status = dq_pkg::ST_FULL;
        end else begin
          ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
          ring_words[ring_head] = r.value;
          ring_fill++;
        end
      end
      dq_pkg::REQ_POP_BACK: begin
        if (ring_fill == 0) rep.status = dq_pkg::ST_EMPTY;
        else ring_fill--;
      end
      dq_pkg::REQ_POP_FRONT: begin
        if (ring_fill == 0) begin
          rep.status = dq_pkg::ST_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % CAPACITY;
          ring_fill--;
        end
      end
      dq_pkg::REQ_READ: begin
        if (idx >= 0) begin
          // Count from the front.
          if (idx < ring_fill) rep.rd = ring_words[(ring_head + idx) % CAPACITY];
          else rep.status = dq_pkg::ST_RANGE;
        end else begin
          // Count from the back: -1 is the last element.
          back = -idx;
          if (back <= ring_fill) rep.rd = ring_words[(ring_head + ring_fill - back) % CAPACITY];
          else rep.status = dq_pkg::ST_RANGE;
        end
      end
      dq_pkg::REQ_CLEAR: begin
        ring_fill = 0;
        ring_head = 0;
      end
      default: begin
        // Spare codes leave everything untouched.
      end
    endcase
    rep.count = ring_fill[COUNT_W-1:0];
    return rep;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Queue one request and track the element count it leaves behind.
  task automatic add_req(input logic [REQ_W-1:0] kind, input logic signed [DATA_W-1:0] val,
                         input logic signed [IDX_W-1:0] idx);
    deq_req_t r;
    r.kind  = kind;
    r.value = val;
    r.index = idx;
    pending_reqs = {pending_reqs, r};
    case (kind)
      dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: if (gen_fill < CAPACITY) gen_fill++;
      dq_pkg::REQ_POP_BACK, dq_pkg::REQ_POP_FRONT:   if (gen_fill > 0) gen_fill--;
      dq_pkg::REQ_CLEAR:                             gen_fill = 0;
      default: ;
    endcase
  endtask

  // Mostly full-width random words, now and then an extreme.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return VAL_ONES;
      3:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random index bits for requests that ignore the index.
  function automatic logic signed [IDX_W-1:0] noise_index();
    logic [31:0] raw;
    raw = $urandom;
    return raw[IDX_W-1:0];
  endfunction

  // Aim most reads inside the live window, from either end; the rest are noise.
  function automatic logic signed [IDX_W-1:0] pick_index();
    int idx;
    if (gen_fill > 0 && $urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 1)) idx = $urandom_range(0, gen_fill - 1);
      else idx = -int'($urandom_range(1, gen_fill));
    end else begin
      idx = $urandom;
    end
    return idx[IDX_W-1:0];
  endfunction

  task automatic add_mixed(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) add_req(dq_pkg::REQ_PUSH_BACK, pick_value(), noise_index());
      else if (pick < 40) add_req(dq_pkg::REQ_PUSH_FRONT, pick_value(), noise_index());
      else if (pick < 55) add_req(dq_pkg::REQ_POP_BACK, pick_value(), noise_index());
      else if (pick < 70) add_req(dq_pkg::REQ_POP_FRONT, pick_value(), noise_index());
      else if (pick < 95) add_req(dq_pkg::REQ_READ, pick_value(), pick_index());
      else if (pick < 97) add_req(dq_pkg::REQ_CLEAR, pick_value(), noise_index());
      else if (pick < 99) add_req(REQ_SPARE_6, pick_value(), noise_index());
      else add_req(REQ_SPARE_7, pick_value(), noise_index());
    end
  endtask

  task automatic build_requests();
    int unsigned pick;
    gen_fill = 0;
    // Directed: empty pops and reads, extreme words at both ends, reads at both
    // ends and just outside, index extremes, spare codes, clear, front wrap.
    add_req(dq_pkg::REQ_POP_BACK, VAL_ONES, '0);
    add_req(dq_pkg::REQ_POP_FRONT, VAL_ONES, '0);
    add_req(dq_pkg::REQ_READ, '0, 11'sd0);
    add_req(dq_pkg::REQ_READ, '0, -11'sd1);
    add_req(dq_pkg::REQ_PUSH_BACK, VAL_MAX, '0);
    add_req(dq_pkg::REQ_PUSH_FRONT, VAL_MIN, '0);
    add_req(dq_pkg::REQ_PUSH_BACK, VAL_ONES, '0);
    add_req(dq_pkg::REQ_PUSH_FRONT, '0, '0);
    add_req(dq_pkg::REQ_READ, '0, 11'sd0);
    add_req(dq_pkg::REQ_READ, '0, -11'sd1);
    add_req(dq_pkg::REQ_READ, '0, 11'sd3);
    add_req(dq_pkg::REQ_READ, '0, -11'sd4);
    add_req(dq_pkg::REQ_READ, '0, 11'sd4);
    add_req(dq_pkg::REQ_READ, '0, -11'sd5);
    add_req(dq_pkg::REQ_READ, '0, 11'sd1023);
    add_req(dq_pkg::REQ_READ, '0, -11'sd1024);
    add_req(REQ_SPARE_6, VAL_ONES, -11'sd1);
    add_req(REQ_SPARE_7, VAL_ONES, -11'sd1);
    add_req(dq_pkg::REQ_POP_FRONT, '0, '0);
    add_req(dq_pkg::REQ_POP_BACK, '0, '0);
    add_req(dq_pkg::REQ_CLEAR, VAL_ONES, -11'sd1);
    add_req(dq_pkg::REQ_READ, '0, 11'sd0);
    add_req(dq_pkg::REQ_PUSH_FRONT, VAL_MAX, '0);
    add_req(dq_pkg::REQ_READ, '0, -11'sd1);
    add_req(dq_pkg::REQ_POP_BACK, '0, '0);

    add_mixed(60);

    // Fill to capacity from both ends with reads sprinkled in.
    while (gen_fill < CAPACITY) begin
      pick = $urandom_range(0, 99);
      if (pick < 47) add_req(dq_pkg::REQ_PUSH_BACK, pick_value(), noise_index());
      else if (pick < 94) add_req(dq_pkg::REQ_PUSH_FRONT, pick_value(), noise_index());
      else add_req(dq_pkg::REQ_READ, pick_value(), pick_index());
    end

    // Hammer the full queue: refused pushes and reads at the index extremes.
    add_req(dq_pkg::REQ_PUSH_BACK, VAL_MAX, '0);
    add_req(dq_pkg::REQ_PUSH_FRONT, VAL_MIN, '0);
    add_req(dq_pkg::REQ_READ, '0, -11'sd1024);
    add_req(dq_pkg::REQ_READ, '0, 11'sd1023);
    add_req(dq_pkg::REQ_READ, '0, 11'sd0);
    add_req(dq_pkg::REQ_READ, '0, -11'sd1);
    repeat (14) begin
      if ($urandom_range(0, 1)) begin
        add_req(dq_pkg::REQ_READ, pick_value(), pick_index());
      end else begin
        add_req($urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT,
                pick_value(), noise_index());
      end
    end

    // Drain partway, then clear and finish with a mixed tail.
    repeat (40) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) add_req(dq_pkg::REQ_POP_BACK, pick_value(), noise_index());
      else if (pick < 8) add_req(dq_pkg::REQ_POP_FRONT, pick_value(), noise_index());
      else add_req(dq_pkg::REQ_READ, pick_value(), pick_index());
    end
    add_req(dq_pkg::REQ_CLEAR, '0, '0);
    add_mixed(40);
  endtask

  // Driver: change inputs on the falling edge; hold a request until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      req_type_i <= '0;
      value_i    <= '0;
      index_i    <= '0;
    end else if (start && !req_taken) begin
      // Hold the current request; the block has not taken it yet.
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (pending_reqs.size() > NO_IDLE_TAIL && $urandom_range(0, 9) == 0) begin
      // Open an idle burst; this cycle counts as its first.
      gap_left = $urandom_range(1, 19) - 1;
      start <= 1'b0;
    end else begin
      start      <= 1'b1;
      req_type_i <= pending_reqs[0].kind;
      value_i    <= pending_reqs[0].value;
      index_i    <= pending_reqs[0].index;
    end
  end

  // Monitor: predict on every accepted request, check every strobed reply.
  always @(posedge clk_i) begin
    deq_req_t   taken_req;
    deq_reply_t new_rep;
    deq_reply_t exp_rep;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        req_taken = 1'b1;
        taken_req = pending_reqs[0];
        pending_reqs.delete(0);
        new_rep = deque_apply(taken_req);
        expected_replies = {expected_replies, new_rep};
      end
      if (done_o) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply strobed with no request outstanding");
        end else begin
          exp_rep = expected_replies[0];
          expected_replies.delete(0);
          if (read_value_o !== exp_rep.rd)
            report_mismatch($sformatf("read_value got %h want %h", read_value_o, exp_rep.rd));
          if (count_o !== exp_rep.count)
            report_mismatch($sformatf("count got %0d want %0d", count_o, exp_rep.count));
          if (status_o !== exp_rep.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, exp_rep.status));
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue test failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    build_requests();
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Wait for every request to go in and every reply to come back.
    while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(posedge clk_i);
    // Leave room for any stray reply to show up.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule
